// ===== rtl/core/dps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg: shared types and constants of the dash pattern segmenter
// payload words, controller/datapath command and status, pattern codes and
// the fixed scale factors of the dash and space lengths
// ----------------------------------------------------------------------------
package dps_pkg;

    // pattern codes
    localparam logic [2:0] PAT_NONE         = 3'd0;
    localparam logic [2:0] PAT_DOTTED       = 3'd1;
    localparam logic [2:0] PAT_DASH         = 3'd2;
    localparam logic [2:0] PAT_LONG_DASH    = 3'd3;
    localparam logic [2:0] PAT_DASH_DOT     = 3'd4;
    localparam logic [2:0] PAT_DASH_DOT_DOT = 3'd5;

    // configuration register indexes
    localparam int          CFG_IDX_W = 1;
    localparam int          CFG_W     = 13;
    localparam logic [0:0]  CFG_DPI_X = 1'b0;
    localparam logic [0:0]  CFG_DPI_Y = 1'b1;
    localparam logic [12:0] DPI_X_RESET = 13'd96;

    // lengths in hundredths of a millimetre
    localparam logic [7:0] MM_LONG_DASH  = 8'd200;
    localparam logic [7:0] MM_LONG_SPACE = 8'd100;
    localparam logic [7:0] MM_DASH       = 8'd100;
    localparam logic [7:0] MM_SPACE      = 8'd50;

    // minimum dash lengths in dot widths
    localparam logic [2:0] DASH_MIN_LONG = 3'd6;
    localparam logic [2:0] DASH_MIN      = 3'd4;

    // (mm100 * dpi + 1270) / 2540 by reciprocal: exact for numerators below 2^21
    localparam int          NUM_W       = 21;
    localparam int          RECIP_W     = 23;
    localparam int          PROD_W      = NUM_W + RECIP_W;
    localparam int          SCALE_SHIFT = 34;
    localparam int          QUO_W       = PROD_W - SCALE_SHIFT;
    localparam logic [20:0] SCALE_ROUND = 21'd1270;
    localparam logic [22:0] SCALE_RECIP = 23'd6763729;

    // internal widths
    localparam int LEN_W  = 16;
    localparam int LEFT_W = 18;
    localparam int SEG_W  = 11;
    localparam int ADV_W  = 12;

    typedef struct packed {
        logic [15:0] line_length;
        logic [2:0]  pattern;
        logic [7:0]  line_height;
    } t_seg_req;

    typedef struct packed {
        logic [15:0] seg_start;
        logic [15:0] seg_length;
        logic        last;
        logic        truncated;
    } t_seg_word;

    typedef struct packed {
        logic load;
        logic num_en;
        logic num_sel_space;
        logic mul_en;
        logic dash_en;
        logic space_en;
        logic step;
        logic out_load;
        logic out_last;
        logic out_trunc;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic cap;
        logic pend;
    } t_dp_status;

endpackage

// ===== rtl/core/dps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_datapath: segment datapath of the dash pattern segmenter
// dash/space scaling through two shared multipliers, the segment walker with
// its pending segment, the dpi register and the output word register
// ----------------------------------------------------------------------------
module dps_datapath
    import dps_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  t_seg_req             i_in_word,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output t_seg_word            o_out_word
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [1:0] {
        PH_DOT1,
        PH_DOT2,
        PH_DASH
    } t_phase;

    logic [CFG_W-1:0]   r_dpi_x;
    logic [LEN_W-1:0]   r_end;
    logic [2:0]         r_pat;
    logic [7:0]         r_dot;
    logic [SEG_W-1:0]   r_dash;
    logic [SEG_W-1:0]   r_space;
    logic [NUM_W-1:0]   r_num;
    logic [PROD_W-1:0]  r_prod;
    logic [LEFT_W-1:0]  r_left;
    t_phase             r_phase;
    logic [CNT_W-1:0]   r_count;
    logic [LEN_W-1:0]   r_pend_start;
    logic [LEN_W-1:0]   r_pend_len;
    logic               r_pend_valid;
    t_seg_word          r_out_word;

    logic               is_long;
    logic [7:0]         mm_sel;
    logic [QUO_W-1:0]   quo;
    logic [SEG_W-1:0]   quo_ext;
    logic [SEG_W-1:0]   dash_min;
    logic [SEG_W-1:0]   space_min;
    logic [8:0]         two_d;
    logic               lt_end;
    logic               le_end;
    logic               step_emit;
    logic [SEG_W-1:0]   step_w;
    logic [ADV_W-1:0]   step_adv;
    t_phase             n_phase;
    logic [LEN_W-1:0]   rem;
    logic [LEN_W-1:0]   seg_len;
    logic               cap;

    assign is_long = (r_pat == PAT_LONG_DASH);
    assign mm_sel  = is_long ? (i_cmd.num_sel_space ? MM_LONG_SPACE : MM_LONG_DASH)
                             : (i_cmd.num_sel_space ? MM_SPACE : MM_DASH);
    assign quo     = r_prod[SCALE_SHIFT +: QUO_W];
    assign quo_ext = SEG_W'(quo);

    // 6d or 4d for the dash, 2d or floor(1.5d) for the space
    assign dash_min  = is_long ? SEG_W'(r_dot) * SEG_W'(DASH_MIN_LONG)
                               : SEG_W'(r_dot) * SEG_W'(DASH_MIN);
    assign space_min = is_long ? SEG_W'({r_dot, 1'b0})
                               : SEG_W'(r_dot) + SEG_W'(r_dot[7:1]);

    assign two_d  = {r_dot, 1'b0};
    assign lt_end = (r_left < LEFT_W'(r_end));
    assign le_end = (r_left <= LEFT_W'(r_end));

    always_comb begin
        step_emit = 1'b0;
        step_w    = '0;
        step_adv  = '0;
        n_phase   = r_phase;
        case (r_pat) inside
            PAT_DOTTED: begin
                step_emit = lt_end;
                step_w    = SEG_W'(r_dot);
                step_adv  = ADV_W'(two_d);
            end
            PAT_DASH, PAT_LONG_DASH: begin
                step_emit = lt_end;
                step_w    = r_dash;
                step_adv  = ADV_W'(r_dash) + ADV_W'(r_space);
            end
            PAT_DASH_DOT, PAT_DASH_DOT_DOT: begin
                case (r_phase)
                    PH_DOT1: begin
                        step_emit = lt_end;
                        step_w    = SEG_W'(r_dot);
                        step_adv  = ADV_W'(two_d);
                        n_phase   = (r_pat == PAT_DASH_DOT_DOT) ? PH_DOT2 : PH_DASH;
                    end
                    PH_DOT2: begin
                        step_emit = le_end;
                        step_w    = SEG_W'(r_dot);
                        step_adv  = ADV_W'(two_d);
                        n_phase   = PH_DASH;
                    end
                    PH_DASH: begin
                        step_emit = le_end;
                        step_w    = r_dash;
                        step_adv  = ADV_W'(r_dash) + ADV_W'(r_dot);
                        n_phase   = PH_DOT1;
                    end
                    default: begin
                        step_emit = 1'b0;
                    end
                endcase
            end
            default: begin
                step_emit = 1'b0;
            end
        endcase
    end

    // left never passes the line end when a segment is emitted
    assign rem     = r_end - r_left[LEN_W-1:0];
    assign seg_len = (LEN_W'(step_w) > rem) ? rem : LEN_W'(step_w);
    assign cap     = (r_count == CNT_W'(MAX_SEGMENTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpi_x      <= DPI_X_RESET;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_DPI_X)) begin
                r_dpi_x <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_pend_valid <= 1'b0;
                r_count      <= '0;
            end else if (i_cmd.step && step_emit && !cap) begin
                r_pend_valid <= 1'b1;
                r_count      <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_end   <= i_in_word.line_length;
            r_pat   <= i_in_word.pattern;
            r_dot   <= (i_in_word.line_height == 8'd0) ? 8'd1 : i_in_word.line_height;
            r_left  <= '0;
            r_phase <= PH_DOT1;
        end else if (i_cmd.step && step_emit && !cap) begin
            r_left       <= r_left + LEFT_W'(step_adv);
            r_phase      <= n_phase;
            r_pend_start <= r_left[LEN_W-1:0];
            r_pend_len   <= seg_len;
        end
        if (i_cmd.num_en) begin
            r_num <= NUM_W'(mm_sel) * NUM_W'(r_dpi_x) + SCALE_ROUND;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(SCALE_RECIP);
        end
        if (i_cmd.dash_en) begin
            r_dash <= (quo_ext < dash_min) ? dash_min : quo_ext;
        end
        if (i_cmd.space_en) begin
            r_space <= (quo_ext < space_min) ? space_min : quo_ext;
        end
        if (i_cmd.out_load) begin
            r_out_word.seg_start  <= r_pend_start;
            r_out_word.seg_length <= r_pend_len;
            r_out_word.last       <= i_cmd.out_last;
            r_out_word.truncated  <= i_cmd.out_trunc;
        end
    end

    assign o_status.emit = step_emit;
    assign o_status.cap  = cap;
    assign o_status.pend = r_pend_valid;
    assign o_out_word    = r_out_word;

endmodule

// ===== rtl/core/dps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_ctrl: controller of the dash pattern segmenter
// sequences the scale steps, then walks the segments one per cycle while the
// output register is free, and owns the output valid
// ----------------------------------------------------------------------------
module dps_ctrl
    import dps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NUM,
        S_MUL,
        S_DIV_DASH,
        S_DIV_SPACE,
        S_RUN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    out_free;
    t_dp_cmd cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                cmd.num_en = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en        = 1'b1;
                cmd.num_en        = 1'b1;
                cmd.num_sel_space = 1'b1;
                n_state           = S_DIV_DASH;
            end
            S_DIV_DASH: begin
                cmd.dash_en = 1'b1;
                cmd.mul_en  = 1'b1;
                n_state     = S_DIV_SPACE;
            end
            S_DIV_SPACE: begin
                cmd.space_en = 1'b1;
                n_state      = S_RUN;
            end
            S_RUN: begin
                if (out_free) begin
                    cmd.step = 1'b1;
                    if (!i_status.emit) begin
                        // run over: flush the pending segment as last
                        cmd.out_load = i_status.pend;
                        cmd.out_last = 1'b1;
                        n_state      = S_IDLE;
                    end else if (i_status.cap) begin
                        cmd.out_load  = 1'b1;
                        cmd.out_last  = 1'b1;
                        cmd.out_trunc = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        cmd.out_load = i_status.pend;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // nothing is taken while reset is held
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== rtl/core/dash_pattern_segmenter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dash_pattern_segmenter: splits one decoration line into drawn segments
// takes a line request (length, pattern, thickness) and emits its dotted,
// dash, long dash, dash-dot or dash-dot-dot segments as start and length
// ----------------------------------------------------------------------------
// One request is worked on at a time. After a request word is taken, the
// states NUM, MUL, DIV_DASH and DIV_SPACE scale the dash and space lengths
// from dpi_x through two shared multipliers (mm by dpi_x, then by the
// reciprocal of 2540, rounded to nearest), then the segment walker takes
// one step per cycle while the output side keeps up. From one taken word to
// the next the input is busy through the scale states, the walk steps, one
// closing step that hands out the final word, and the idle cycle that takes
// the next request; a capped run closes on its cap step. Pattern none,
// codes 6 and 7 and a zero line length give no words. The walker holds each
// segment back one step so that the final word can carry last, and
// truncated when the run hit the segment cap. The dot width is the line
// height (raised to 1). dpi_y is accepted on the config port but has no
// effect, since it cancels in the dot width. The walker stalls while a
// segment word waits unaccepted in the output register.
// ----------------------------------------------------------------------------
module dash_pattern_segmenter
    import dps_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes: index 0 dpi_x, index 1 dpi_y
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // request word
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_seg_req             i_in_word,
    // segment word
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_seg_word            o_out_word
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // controller: scale sequence, segment walk and output valid
    dps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // datapath: dpi register, scaling, segment walker and output word
    dps_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_word  (o_out_word)
    );

endmodule
